// ===== rtl/bfha_pkg.sv =====
package bfha_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);

    localparam int ADDR_W  = 12;   // unit index, next pointer
    localparam int SIZE_W  = 16;   // stored block size
    localparam int UNITS_W = 13;   // request size in units
    localparam int BRK_W   = 13;   // break pointer
    localparam int STEP_W  = 13;   // walk step counter
    localparam int BYTES_W = 16;
    localparam int CFG_W   = 12;
    localparam int SUM_W   = 17;   // address plus size, unwrapped

    localparam logic [STEP_W-1:0]  LAST_STEP        = STEP_W'(HEAP_UNITS);
    localparam logic [CFG_W-1:0]   MIN_GROWTH_RESET = CFG_W'(1024);
    localparam logic [BRK_W-1:0]   BRK_RESET        = BRK_W'(1);

    // register byte addresses
    localparam logic [1:0]         REG_MIN_GROWTH   = 2'd0;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_G_START,
        S_G_FIRST,
        S_G_STEP,
        S_G_DECIDE,
        S_G_SPLIT1,
        S_G_SPLIT2,
        S_RW_START,
        S_RW_STEP,
        S_RC_BP,
        S_RC_N,
        S_RC_P,
        S_RC_CAP,
        S_RC_WBP,
        S_RC_WP,
        S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_REL_FREE,
        OP_GROW,
        OP_SET_OOM,
        OP_G_START,
        OP_G_FIRST,
        OP_G_STEP,
        OP_G_EXACT,
        OP_G_SPLIT1,
        OP_G_SPLIT2,
        OP_RW_START,
        OP_RW_STEP,
        OP_RC_BP,
        OP_RC_N,
        OP_RC_P,
        OP_RC_CAP,
        OP_RC_WBP,
        OP_RC_WP,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic free_ok;
        logic placed;
        logic walk_limit;
        logic g_end;
        logic found;
        logic exact;
        logic grow_ok;
    } t_dp_status;

endpackage

// ===== rtl/best_fit_heap_allocator.sv =====
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_kind, i_request_bytes, i_block_address
// out       output     o_out_valid / i_out_stall o_status, o_payload_address
// config    apb        psel, penable, pwrite     register 0: min growth units (12 bits)
//
// one word in, one word out; the next word is taken as soon as the result sits
// in the output register. an allocate reads one header per list node visited
// and, when no block fits exactly, carves the best one before the result goes
// out; a free walks the list to its insertion point and merges with adjacent
// neighbours; a heap growth adds a free and a second full walk.
// reset is synchronous, active low: empty list, break at unit 1, growth 1024.
// a stalled result holds; the walk stalls only in the final hand-off.
module best_fit_heap_allocator
    import bfha_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [BYTES_W-1:0] i_request_bytes,
    input  logic [ADDR_W-1:0]  i_block_address,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_status,
    output logic [ADDR_W-1:0]  o_payload_address,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic              cfg_we;
    logic [CFG_W-1:0]  min_growth;

    // single register at byte address 0
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_MIN_GROWTH);
    assign prdata = 32'(min_growth);

    // sequencer: steps the datapath through search, carve, growth and free
    bfha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // header memories, list pointers and the result register
    bfha_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_kind           (i_kind),
        .i_request_bytes  (i_request_bytes),
        .i_block_address  (i_block_address),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (pwdata[CFG_W-1:0]),
        .o_cfg_min_growth (min_growth),
        .o_res_status     (o_status),
        .o_res_payload    (o_payload_address)
    );

endmodule

// ===== rtl/bfha_ram.sv =====
module bfha_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bfha_datapath.sv =====
module bfha_datapath
    import bfha_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic                i_kind,
    input  logic [BYTES_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0]   i_block_address,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic [CFG_W-1:0]    o_cfg_min_growth,
    output logic                o_res_status,
    output logic [ADDR_W-1:0]   o_res_payload
);

    // request
    logic               r_kind, n_kind;
    logic [UNITS_W-1:0] r_units, n_units;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    // list state
    logic [ADDR_W-1:0]  r_sentinel, n_sentinel;
    logic [ADDR_W-1:0]  r_rover, n_rover;
    logic [BRK_W-1:0]   r_brk, n_brk;
    logic [CFG_W-1:0]   r_mg;
    // walk state
    logic [ADDR_W-1:0]  r_p, n_p, r_prev, n_prev, r_n, n_n, r_bp, n_bp;
    logic [STEP_W-1:0]  r_steps, n_steps;
    logic [ADDR_W-1:0]  r_best, n_best, r_bestprev, n_bestprev, r_bestnx, n_bestnx;
    logic [SIZE_W-1:0]  r_bestsz, n_bestsz;
    logic               r_found, n_found;
    logic [SIZE_W-1:0]  r_szbp, n_szbp, r_szn, n_szn, r_szp, n_szp, r_bpsz, n_bpsz;
    logic [ADDR_W-1:0]  r_nxn, n_nxn, r_bpnx, n_bpnx;
    logic [ADDR_W-1:0]  r_rd_addr, n_rd_addr;
    // result
    logic               r_status, n_status, r_o_status, n_o_status;
    logic [ADDR_W-1:0]  r_pay, n_pay, r_o_pay, n_o_pay;

    // memory ports
    logic               nx_we, sz_we;
    logic [ADDR_W-1:0]  nx_waddr, sz_waddr, nx_wdata;
    logic [SIZE_W-1:0]  sz_wdata;
    logic [ADDR_W-1:0]  nx_q;
    logic [SIZE_W-1:0]  sz_q;

    // read data with the sentinel at unit 0
    logic [ADDR_W-1:0]  dnext;
    logic [SIZE_W-1:0]  dsize;

    logic [UNITS_W-1:0] units_in;
    logic [UNITS_W-1:0] grow_nu;
    logic [BRK_W:0]     room;
    logic               grow_ok;
    logic               placed;
    logic               g_end;
    logic               better;
    logic [SIZE_W-1:0]  rest;
    logic               fwd, back;

    bfha_ram #(.DATA_W(ADDR_W), .DEPTH(HEAP_UNITS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we && (nx_waddr != '0)),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (n_rd_addr),
        .o_rdata (nx_q)
    );

    bfha_ram #(.DATA_W(SIZE_W), .DEPTH(HEAP_UNITS)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (sz_we && (sz_waddr != '0)),
        .i_waddr (sz_waddr),
        .i_wdata (sz_wdata),
        .i_raddr (n_rd_addr),
        .o_rdata (sz_q)
    );

    assign dnext = (r_rd_addr == '0) ? r_sentinel : nx_q;
    assign dsize = (r_rd_addr == '0) ? '0 : sz_q;

    // payload rounded up to whole units, plus the header unit
    assign units_in = UNITS_W'(i_request_bytes >> UNIT_SHIFT)
                    + UNITS_W'(|i_request_bytes[UNIT_SHIFT-1:0]) + UNITS_W'(1);

    assign grow_nu = (r_units < UNITS_W'(r_mg)) ? UNITS_W'(r_mg) : r_units;
    assign room    = (BRK_W+1)'(HEAP_UNITS) - (BRK_W+1)'(r_brk);
    assign grow_ok = (r_brk <= BRK_W'(HEAP_UNITS)) && ((BRK_W+1)'(grow_nu) <= room);

    // insertion point: bp between p and n, or past the wraparound
    assign placed = ((r_bp > r_p) && (r_bp < dnext))
                 || ((r_p >= dnext) && ((r_bp > r_p) || (r_bp < dnext)));

    assign g_end  = (r_p == r_rover) || (r_steps == LAST_STEP);
    assign better = (dsize >= SIZE_W'(r_units)) && (!r_found || (dsize < r_bestsz));
    assign rest   = r_bestsz - SIZE_W'(r_units);

    assign fwd  = (r_n != '0)
               && ((SUM_W'(r_bp) + SUM_W'(r_szbp)) == SUM_W'(r_n));
    assign back = (r_p != '0)
               && ((SUM_W'(r_p) + SUM_W'(r_szp)) == SUM_W'(r_bp));

    always_comb begin
        n_kind     = r_kind;     n_units    = r_units;    n_addr     = r_addr;
        n_sentinel = r_sentinel; n_rover    = r_rover;    n_brk      = r_brk;
        n_p        = r_p;        n_prev     = r_prev;     n_n        = r_n;
        n_bp       = r_bp;       n_steps    = r_steps;
        n_best     = r_best;     n_bestprev = r_bestprev; n_bestnx   = r_bestnx;
        n_bestsz   = r_bestsz;   n_found    = r_found;
        n_szbp     = r_szbp;     n_szn      = r_szn;      n_szp      = r_szp;
        n_bpsz     = r_bpsz;     n_nxn      = r_nxn;      n_bpnx     = r_bpnx;
        n_rd_addr  = r_rd_addr;
        n_status   = r_status;   n_pay      = r_pay;
        n_o_status = r_o_status; n_o_pay    = r_o_pay;
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
        sz_we = 1'b0; sz_waddr = '0; sz_wdata = '0;

        case (i_cmd.op)
            OP_LOAD: begin
                n_kind   = i_kind;
                n_units  = units_in;
                n_addr   = i_block_address;
                n_status = 1'b0;
                n_pay    = '0;
            end
            OP_REL_FREE: begin
                n_bp = r_addr - ADDR_W'(1);
            end
            OP_GROW: begin
                sz_we    = 1'b1;
                sz_waddr = r_brk[ADDR_W-1:0];
                sz_wdata = SIZE_W'(grow_nu);
                n_bp     = r_brk[ADDR_W-1:0];
                n_brk    = r_brk + BRK_W'(grow_nu);
            end
            OP_SET_OOM: begin
                n_status = 1'b1;
                n_pay    = '0;
            end
            OP_G_START: begin
                n_prev    = r_rover;
                n_found   = 1'b0;
                n_rd_addr = r_rover;
            end
            OP_G_FIRST: begin
                n_p       = dnext;
                n_steps   = '0;
                n_rd_addr = dnext;
            end
            OP_G_STEP: begin
                if (better) begin
                    n_found    = 1'b1;
                    n_best     = r_p;
                    n_bestprev = r_prev;
                    n_bestsz   = dsize;
                    n_bestnx   = dnext;
                end
                if (!g_end) begin
                    n_prev    = r_p;
                    n_p       = dnext;
                    n_rd_addr = dnext;
                    n_steps   = r_steps + STEP_W'(1);
                end
            end
            OP_G_EXACT: begin
                nx_we    = 1'b1;
                nx_waddr = r_bestprev;
                nx_wdata = r_bestnx;
                if (r_bestprev == '0) begin
                    n_sentinel = r_bestnx;
                end
                n_rover = r_bestprev;
                n_pay   = r_best + ADDR_W'(1);
            end
            OP_G_SPLIT1: begin
                // shrink the block, the tail becomes the grant
                sz_we    = 1'b1;
                sz_waddr = r_best;
                sz_wdata = rest;
                n_best   = r_best + rest[ADDR_W-1:0];
            end
            OP_G_SPLIT2: begin
                sz_we    = 1'b1;
                sz_waddr = r_best;
                sz_wdata = SIZE_W'(r_units);
                n_rover  = r_bestprev;
                n_pay    = r_best + ADDR_W'(1);
            end
            OP_RW_START: begin
                n_p       = r_rover;
                n_steps   = '0;
                n_rd_addr = r_rover;
            end
            OP_RW_STEP: begin
                if (placed) begin
                    n_n = dnext;
                end else begin
                    n_p       = dnext;
                    n_rd_addr = dnext;
                    n_steps   = r_steps + STEP_W'(1);
                end
            end
            OP_RC_BP: begin
                n_rd_addr = r_bp;
            end
            OP_RC_N: begin
                n_szbp    = dsize;
                n_rd_addr = r_n;
            end
            OP_RC_P: begin
                n_szn     = dsize;
                n_nxn     = dnext;
                n_rd_addr = r_p;
            end
            OP_RC_CAP: begin
                n_szp = dsize;
            end
            OP_RC_WBP: begin
                // merge with the upper neighbour
                n_bpsz   = fwd ? (r_szbp + r_szn) : r_szbp;
                n_bpnx   = fwd ? r_nxn : r_n;
                nx_we    = 1'b1;
                nx_waddr = r_bp;
                nx_wdata = n_bpnx;
                sz_we    = 1'b1;
                sz_waddr = r_bp;
                sz_wdata = n_bpsz;
            end
            OP_RC_WP: begin
                // merge with the lower neighbour
                nx_we    = 1'b1;
                nx_waddr = r_p;
                nx_wdata = back ? r_bpnx : r_bp;
                if (back) begin
                    sz_we    = 1'b1;
                    sz_waddr = r_p;
                    sz_wdata = r_szp + r_bpsz;
                end
                if (r_p == '0) begin
                    n_sentinel = nx_wdata;
                end
                n_rover = r_p;
            end
            OP_EMIT: begin
                n_o_status = r_status;
                n_o_pay    = r_pay;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sentinel <= '0;
            r_rover    <= '0;
            r_brk      <= BRK_RESET;
            r_mg       <= MIN_GROWTH_RESET;
            r_found    <= 1'b0;
        end else begin
            r_sentinel <= n_sentinel;
            r_rover    <= n_rover;
            r_brk      <= n_brk;
            r_found    <= n_found;
            if (i_cfg_we) begin
                r_mg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;     r_units    <= n_units;    r_addr     <= n_addr;
        r_p        <= n_p;        r_prev     <= n_prev;     r_n        <= n_n;
        r_bp       <= n_bp;       r_steps    <= n_steps;
        r_best     <= n_best;     r_bestprev <= n_bestprev; r_bestnx   <= n_bestnx;
        r_bestsz   <= n_bestsz;
        r_szbp     <= n_szbp;     r_szn      <= n_szn;      r_szp      <= n_szp;
        r_bpsz     <= n_bpsz;     r_nxn      <= n_nxn;      r_bpnx     <= n_bpnx;
        r_rd_addr  <= n_rd_addr;
        r_status   <= n_status;   r_pay      <= n_pay;
        r_o_status <= n_o_status; r_o_pay    <= n_o_pay;
    end

    assign o_status.kind       = r_kind;
    assign o_status.free_ok    = (r_addr >= ADDR_W'(2))
                              && (BRK_W'(r_addr - ADDR_W'(1)) < r_brk);
    assign o_status.placed     = placed;
    assign o_status.walk_limit = !placed && (r_steps == LAST_STEP);
    assign o_status.g_end      = g_end;
    assign o_status.found      = r_found;
    assign o_status.exact      = (r_bestsz == SIZE_W'(r_units));
    assign o_status.grow_ok    = grow_ok;

    assign o_cfg_min_growth = r_mg;
    assign o_res_status     = r_o_status;
    assign o_res_payload    = r_o_pay;

endmodule

// ===== rtl/bfha_ctrl.sv =====
module bfha_ctrl
    import bfha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_attempt, n_attempt;     // heap already grown for this request
    logic   r_after_grow, n_after_grow;
    logic   r_out_valid, n_out_valid;
    logic   emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_attempt    <= 1'b0;
            r_after_grow <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_attempt    <= n_attempt;
            r_after_grow <= n_after_grow;
            r_out_valid  <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_attempt    = r_attempt;
        n_after_grow = r_after_grow;
        o_cmd.op     = OP_NONE;
        emit         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_attempt    = 1'b0;
                n_after_grow = 1'b0;
                if (i_status.kind) begin
                    if (i_status.free_ok) begin
                        o_cmd.op = OP_REL_FREE;
                        n_state  = S_RW_START;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_G_START;
                end
            end
            S_G_START: begin
                o_cmd.op = OP_G_START;
                n_state  = S_G_FIRST;
            end
            S_G_FIRST: begin
                o_cmd.op = OP_G_FIRST;
                n_state  = S_G_STEP;
            end
            S_G_STEP: begin
                o_cmd.op = OP_G_STEP;
                if (i_status.g_end) begin
                    n_state = S_G_DECIDE;
                end
            end
            S_G_DECIDE: begin
                if (i_status.found) begin
                    if (i_status.exact) begin
                        o_cmd.op = OP_G_EXACT;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_G_SPLIT1;
                    end
                end else if (!r_attempt && i_status.grow_ok) begin
                    o_cmd.op     = OP_GROW;
                    n_attempt    = 1'b1;
                    n_after_grow = 1'b1;
                    n_state      = S_RW_START;
                end else begin
                    o_cmd.op = OP_SET_OOM;
                    n_state  = S_EMIT;
                end
            end
            S_G_SPLIT1: begin
                o_cmd.op = OP_G_SPLIT1;
                n_state  = S_G_SPLIT2;
            end
            S_G_SPLIT2: begin
                o_cmd.op = OP_G_SPLIT2;
                n_state  = S_EMIT;
            end
            S_RW_START: begin
                o_cmd.op = OP_RW_START;
                n_state  = S_RW_STEP;
            end
            S_RW_STEP: begin
                o_cmd.op = OP_RW_STEP;
                if (i_status.placed) begin
                    n_state = S_RC_BP;
                end else if (i_status.walk_limit) begin
                    n_state = r_after_grow ? S_G_START : S_EMIT;
                end
            end
            S_RC_BP: begin
                o_cmd.op = OP_RC_BP;
                n_state  = S_RC_N;
            end
            S_RC_N: begin
                o_cmd.op = OP_RC_N;
                n_state  = S_RC_P;
            end
            S_RC_P: begin
                o_cmd.op = OP_RC_P;
                n_state  = S_RC_CAP;
            end
            S_RC_CAP: begin
                o_cmd.op = OP_RC_CAP;
                n_state  = S_RC_WBP;
            end
            S_RC_WBP: begin
                o_cmd.op = OP_RC_WBP;
                n_state  = S_RC_WP;
            end
            S_RC_WP: begin
                o_cmd.op = OP_RC_WP;
                n_state  = r_after_grow ? S_G_START : S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = OP_EMIT;
                    emit     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = emit || (r_out_valid && i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/tb_best_fit_heap_allocator.sv =====
`timescale 1ns / 100ps

module tb_best_fit_heap_allocator;
    import bfha_pkg::*;

    localparam logic       KIND_ALLOC     = 1'b0;
    localparam logic       KIND_FREE      = 1'b1;
    localparam logic       ST_DONE        = 1'b0;
    localparam logic       ST_OOM         = 1'b1;
    localparam int unsigned WALK_MAX      = HEAP_UNITS + 1;

    // dut signals
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [BYTES_W-1:0] i_request_bytes;
    logic [ADDR_W-1:0]  i_block_address;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_status;
    logic [ADDR_W-1:0]  o_payload_address;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    best_fit_heap_allocator uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_request_bytes   (i_request_bytes),
        .i_block_address   (i_block_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_payload_address (o_payload_address),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // one result word of the block
    typedef struct {
        logic              status;
        logic [ADDR_W-1:0] payload;
    } t_grant_word;

    // one row of the directed table; from_live picks the live block at index addr
    typedef struct {
        logic              kind;
        logic [15:0]       bytes;
        logic [ADDR_W-1:0] addr;
        bit                from_live;
        bit                typed;
        logic              exp_status;
        logic [ADDR_W-1:0] exp_payload;
    } t_dir_row;

    t_grant_word pending_grants[$];
    t_dir_row    dir_rows[$];
    int          live_blocks[$];    // payload addresses handed out and not yet freed
    int          freed_blocks[$];   // recently freed payloads, used for double frees
    int          errors;
    bit          idle_on;
    bit          long_hold_req;

    // predictor state: header memory, sentinel link, rover, break, growth register
    int unsigned heap_next [HEAP_UNITS];
    int unsigned heap_size [HEAP_UNITS];
    int unsigned ls_sentinel;
    int unsigned ls_rover;
    int unsigned ls_brk;
    int unsigned ls_growth;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: generous fixed bound on the whole run
    initial begin
        #2s;
        $display("simulation failed");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // predictor of the free list
    // ---------------------------------------------------------------
    function automatic int unsigned link_of(input int unsigned i);
        i = i % HEAP_UNITS;
        return (i == 0) ? ls_sentinel : heap_next[i];
    endfunction

    function automatic void set_link(input int unsigned i, input int unsigned v);
        i = i % HEAP_UNITS;
        v = v % HEAP_UNITS;
        if (i == 0) ls_sentinel = v;
        else heap_next[i] = v;
    endfunction

    function automatic int unsigned size_of(input int unsigned i);
        i = i % HEAP_UNITS;
        return (i == 0) ? 0 : heap_size[i];
    endfunction

    function automatic void set_size(input int unsigned i, input int unsigned v);
        i = i % HEAP_UNITS;
        if (i != 0) heap_size[i] = v & 32'hFFFF;
    endfunction

    // address-ordered insert of header unit bp, merging with both neighbors
    function automatic void insert_free(input int unsigned bp);
        int unsigned p;
        int unsigned n;
        bit          placed;
        p = ls_rover;
        placed = 0;
        for (int unsigned k = 0; k < WALK_MAX; k++) begin
            n = link_of(p);
            if (bp > p && bp < n) begin
                placed = 1;
                break;
            end
            if (p >= n && (bp > p || bp < n)) begin
                placed = 1;
                break;
            end
            p = n;
        end
        if (!placed) return;
        n = link_of(p);
        if (n != 0 && bp + size_of(bp) == n) begin
            set_size(bp, size_of(bp) + size_of(n));
            set_link(bp, link_of(n));
        end else begin
            set_link(bp, n);
        end
        if (p != 0 && p + size_of(p) == bp) begin
            set_size(p, size_of(p) + size_of(bp));
            set_link(p, link_of(bp));
        end else begin
            set_link(p, bp);
        end
        ls_rover = p;
    endfunction

    // one full lap from the rover, smallest fit wins, first met on ties
    function automatic bit best_fit_take(input int unsigned units, output int unsigned pay);
        int unsigned prev, p, best, best_prev, best_sz, s, rest;
        bit          found;
        prev = ls_rover;
        p = link_of(ls_rover);
        best = 0;
        best_prev = 0;
        best_sz = 0;
        found = 0;
        pay = 0;
        for (int unsigned k = 0; k < WALK_MAX; k++) begin
            s = size_of(p);
            if (s >= units && (!found || s < best_sz)) begin
                found = 1;
                best = p;
                best_prev = prev;
                best_sz = s;
            end
            if (p == ls_rover) break;
            prev = p;
            p = link_of(p);
        end
        if (!found) return 0;
        if (best_sz == units) begin
            set_link(best_prev, link_of(best));
        end else begin
            rest = best_sz - units;
            set_size(best, rest);
            best = best + rest;
            set_size(best, units);
        end
        ls_rover = best_prev;
        pay = best + 1;
        return 1;
    endfunction

    function automatic t_grant_word predict_word(input logic kind, input logic [15:0] bytes,
                                                 input logic [ADDR_W-1:0] addr);
        t_grant_word w;
        int unsigned units, pay, grow, up;
        w.status = ST_DONE;
        w.payload = '0;
        if (kind == KIND_FREE) begin
            if (addr >= 2 && addr - 1 < ls_brk) insert_free(addr - 1);
            return w;
        end
        units = (bytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
        for (int attempt = 0; attempt < 2; attempt++) begin
            if (best_fit_take(units, pay)) begin
                w.payload = pay[ADDR_W-1:0];
                return w;
            end
            if (attempt == 0) begin
                // no fit: push the break out and retry once
                grow = (units < ls_growth) ? ls_growth : units;
                if (ls_brk > HEAP_UNITS || grow > HEAP_UNITS - ls_brk) break;
                up = ls_brk;
                set_size(up, grow);
                ls_brk += grow;
                insert_free(up);
            end
        end
        w.status = ST_OOM;
        w.payload = '0;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    // offer one word, hold it until taken, then predict and maybe go idle
    task automatic send_word(input logic kind, input logic [15:0] bytes,
                             input logic [ADDR_W-1:0] addr, output t_grant_word w);
        int gap;
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_request_bytes <= bytes;
        i_block_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        w = predict_word(kind, bytes, addr);
        pending_grants.push_back(w);
        if (kind == KIND_ALLOC && w.status == ST_DONE && w.payload != 0)
            live_blocks.push_back(int'(w.payload));
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for the block to go quiet with every result collected
    task automatic drain_results();
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_growth(input int unsigned v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MIN_GROWTH;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ls_growth = v & 32'hFFF;
        @(posedge i_clk);
    endtask

    function automatic void add_row(input logic kind, input int bytes, input int addr,
                                    input bit from_live, input bit typed,
                                    input logic st, input int pay);
        t_dir_row r;
        r.kind = kind;
        r.bytes = 16'(bytes);
        r.addr = ADDR_W'(addr);
        r.from_live = from_live;
        r.typed = typed;
        r.exp_status = st;
        r.exp_payload = ADDR_W'(pay);
        dir_rows.push_back(r);
    endfunction

    // random word: mostly allocs of small sizes and frees of live blocks
    task automatic send_random();
        t_grant_word w;
        logic [15:0] bytes;
        logic [ADDR_W-1:0] addr;
        int sel, r, idx;
        bytes = 16'($urandom);
        addr = ADDR_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 55 || live_blocks.size() == 0) begin
            r = $urandom_range(0, 99);
            if (r < 80) bytes = 16'($urandom_range(0, 255));
            else if (r < 95) bytes = 16'($urandom_range(0, 2047));
            send_word(KIND_ALLOC, bytes, addr, w);
        end else if (sel < 92) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            addr = ADDR_W'(live_blocks[idx]);
            live_blocks.delete(idx);
            freed_blocks.push_back(int'(addr));
            if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
            send_word(KIND_FREE, bytes, addr, w);
        end else if (sel < 93 && freed_blocks.size() != 0) begin
            // double free of an old block
            addr = ADDR_W'(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
            send_word(KIND_FREE, bytes, addr, w);
        end else begin
            // out-of-range free; never one that would read an unwritten header
            r = $urandom_range(0, 4095);
            if (r >= 2 && r - 1 < ls_brk) r = $urandom_range(0, 1);
            send_word(KIND_FREE, bytes, ADDR_W'(r), w);
        end
    endtask

    // ---------------------------------------------------------------
    // result side: random stall bursts, a long hold on request, checking
    // ---------------------------------------------------------------
    initial begin
        int hold_left;
        int burst_left;
        t_grant_word want;
        hold_left = 0;
        burst_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_grants.size() == 0) begin
                    report("unexpected word", o_payload_address, 0);
                end else begin
                    want = pending_grants.pop_front();
                    if (o_status !== want.status)
                        report("status", o_status, want.status);
                    if (o_payload_address !== want.payload)
                        report("payload", o_payload_address, want.payload);
                end
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        t_grant_word w;
        t_dir_row row;
        logic [ADDR_W-1:0] addr;
        int unsigned growths [5];
        int wait_cycles;

        errors = 0;
        idle_on = 1;
        long_hold_req = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_ALLOC;
        i_request_bytes = '0;
        i_block_address = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // predictor reset
        for (int i = 0; i < HEAP_UNITS; i++) begin
            heap_next[i] = 0;
            heap_size[i] = 0;
        end
        ls_sentinel = 0;
        ls_rover = 0;
        ls_brk = 1;
        ls_growth = 1024;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // directed table, growth at its reset value of 1024
        // first alloc grows the break to 1025 and carves the last unit
        add_row(KIND_ALLOC, 0,     0,    0, 1, ST_DONE, 1025);
        // too large for the heap: out of memory, nothing changes
        add_row(KIND_ALLOC, 65535, 4095, 0, 1, ST_OOM,  0);
        // frees of the sentinel, of unit 0 and past the break are ignored
        add_row(KIND_FREE,  65535, 0,    0, 1, ST_DONE, 0);
        add_row(KIND_FREE,  0,     1,    0, 1, ST_DONE, 0);
        add_row(KIND_FREE,  0,     4095, 0, 1, ST_DONE, 0);
        add_row(KIND_ALLOC, 16,    0,    0, 0, ST_DONE, 0);
        add_row(KIND_ALLOC, 17,    0,    0, 0, ST_DONE, 0);
        add_row(KIND_ALLOC, 32,    0,    0, 0, ST_DONE, 0);
        add_row(KIND_ALLOC, 1,     0,    0, 0, ST_DONE, 0);
        // free the first block, then free it again
        add_row(KIND_FREE,  0,     0,    1, 1, ST_DONE, 0);
        add_row(KIND_FREE,  0,     1025, 0, 1, ST_DONE, 0);
        add_row(KIND_ALLOC, 0,     0,    0, 0, ST_DONE, 0);
        // frees in the middle merge with neighbors on both sides
        add_row(KIND_FREE,  0,     1,    1, 1, ST_DONE, 0);
        add_row(KIND_FREE,  0,     0,    1, 1, ST_DONE, 0);
        add_row(KIND_ALLOC, 1008,  0,    0, 0, ST_DONE, 0);
        add_row(KIND_ALLOC, 40000, 0,    0, 0, ST_DONE, 0);
        add_row(KIND_ALLOC, 48,    0,    0, 0, ST_DONE, 0);
        add_row(KIND_FREE,  0,     0,    1, 1, ST_DONE, 0);
        add_row(KIND_ALLOC, 32768, 0,    0, 0, ST_DONE, 0);
        add_row(KIND_ALLOC, 15,    0,    0, 0, ST_DONE, 0);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            addr = row.addr;
            if (row.from_live) begin
                if (live_blocks.size() > row.addr) begin
                    addr = ADDR_W'(live_blocks[row.addr]);
                    live_blocks.delete(row.addr);
                    freed_blocks.push_back(int'(addr));
                end else begin
                    addr = 0;
                end
            end
            send_word(row.kind, row.bytes, addr, w);
            if (row.typed) begin
                if (w.status !== row.exp_status)
                    report("table status", w.status, row.exp_status);
                if (w.payload !== row.exp_payload)
                    report("table payload", w.payload, row.exp_payload);
            end
        end

        // random phases, each with its own growth setting, extremes included
        growths[0] = 1;
        growths[1] = $urandom_range(1, 4095);
        growths[2] = 4095;
        growths[3] = 0;
        growths[4] = $urandom_range(1, 4095);
        for (int ph = 0; ph < 5; ph++) begin
            // sender pauses here until every result is back
            i_in_valid <= 1'b0;
            drain_results();
            write_growth(growths[ph]);
            // last phase runs with no idling on either side
            if (ph == 4) idle_on = 0;
            // receiver holds off long enough to back up the input
            if (ph == 1) long_hold_req = 1;
            for (int n = 0; n < 276; n++) send_random();
        end
        i_in_valid <= 1'b0;

        // let the tail drain, bounded
        wait_cycles = 0;
        while (pending_grants.size() != 0 && wait_cycles < 2000000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_grants.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
